// ===== src/addressable_led_pulse_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LED pulse encoder checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_CORE_MACROS_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_CORE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ALED_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ALED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/aled_pkg.sv =====
// ----------------------------------------------------------------------------
// aled_pkg
// Shared types, constants and helpers for the LED pulse encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aled_pkg;

  localparam int TICK_W     = 20;
  localparam int TIME_W     = 16;
  localparam int COLOR_W    = 8;
  localparam int PIXEL_W    = 3 * COLOR_W;
  localparam int BITCNT_W   = $clog2(PIXEL_W + 1);
  localparam int REQ_W      = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LATCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] REG_ONE_LOW   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] REG_LATCH     = 3'd4;

  // Register reset values
  localparam logic [TIME_W-1:0] RST_ONE_HIGH  = 16'd70;
  localparam logic [TIME_W-1:0] RST_ONE_LOW   = 16'd60;
  localparam logic [TIME_W-1:0] RST_ZERO_HIGH = 16'd35;
  localparam logic [TIME_W-1:0] RST_ZERO_LOW  = 16'd80;
  localparam logic [TICK_W-1:0] RST_LATCH     = 20'd10000;

  typedef logic [1:0] aled_op_t;

  localparam aled_op_t OP_TICK  = 2'd0;
  localparam aled_op_t OP_PIXEL = 2'd1;
  localparam aled_op_t OP_LATCH = 2'd2;
  localparam aled_op_t OP_NONE  = 2'd3;

  typedef struct packed {
    aled_op_t             op;
    logic [PIXEL_W-1:0]   color;  // {blue, red, green}
  } aled_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] one_high;
    logic [TIME_W-1:0] one_low;
    logic [TIME_W-1:0] zero_high;
    logic [TIME_W-1:0] zero_low;
    logic [TICK_W-1:0] latch;
  } aled_cfg_t;

  // A programmed count of zero behaves as one
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [TICK_W-1:0] high_time(input logic b, input aled_cfg_t c);
    logic [TIME_W-1:0] t;
    t = b ? c.one_high : c.zero_high;
    return at_least_one(TICK_W'(t));
  endfunction

  function automatic logic [TICK_W-1:0] low_time(input logic b, input aled_cfg_t c);
    logic [TIME_W-1:0] t;
    t = b ? c.one_low : c.zero_low;
    return at_least_one(TICK_W'(t));
  endfunction

endpackage

`default_nettype wire

// ===== src/aled_front.sv =====
// ----------------------------------------------------------------------------
// aled_front
// Accepts input transfers, decodes the request and packs the pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aled_front
  import aled_pkg::*;
(
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [COLOR_W-1:0] in_red,
  input  wire logic [COLOR_W-1:0] in_green,
  input  wire logic [COLOR_W-1:0] in_blue,
  input  wire logic               q_full,
  output      logic               q_push,
  output      aled_item_t         q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.color = {in_blue, in_red, in_green};
    unique case (in_req_type)
      REQ_TICK:  q_item.op = OP_TICK;
      REQ_PIXEL: q_item.op = OP_PIXEL;
      REQ_LATCH: q_item.op = OP_LATCH;
      REQ_RSVD:  q_item.op = OP_NONE;
      default:   q_item.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/aled_queue.sv =====
// ----------------------------------------------------------------------------
// aled_queue
// Short FIFO between the request decoder and the pulse engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aled_queue
  import aled_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire aled_item_t push_item,
  output      logic       full,
  input  wire logic       pop,
  output      logic       not_empty,
  output      aled_item_t head
);

  aled_item_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/aled_regs.sv =====
// ----------------------------------------------------------------------------
// aled_regs
// APB register file holding the pulse and latch tick counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aled_regs
  import aled_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      aled_cfg_t             cfg
);

  aled_cfg_t  cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ONE_HIGH:  cfg_nxt.one_high  = pwdata[TIME_W-1:0];
        REG_ONE_LOW:   cfg_nxt.one_low   = pwdata[TIME_W-1:0];
        REG_ZERO_HIGH: cfg_nxt.zero_high = pwdata[TIME_W-1:0];
        REG_ZERO_LOW:  cfg_nxt.zero_low  = pwdata[TIME_W-1:0];
        REG_LATCH:     cfg_nxt.latch     = pwdata[TICK_W-1:0];
        default:       cfg_nxt = cfg_r;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ONE_HIGH:  prdata = APB_DATA_W'(cfg_r.one_high);
      REG_ONE_LOW:   prdata = APB_DATA_W'(cfg_r.one_low);
      REG_ZERO_HIGH: prdata = APB_DATA_W'(cfg_r.zero_high);
      REG_ZERO_LOW:  prdata = APB_DATA_W'(cfg_r.zero_low);
      REG_LATCH:     prdata = APB_DATA_W'(cfg_r.latch);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high  <= RST_ONE_HIGH;
      cfg_r.one_low   <= RST_ONE_LOW;
      cfg_r.zero_high <= RST_ZERO_HIGH;
      cfg_r.zero_low  <= RST_ZERO_LOW;
      cfg_r.latch     <= RST_LATCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/aled_back.sv =====
// ----------------------------------------------------------------------------
// aled_back
// Pulse engine: runs the bit and latch timer one request per cycle while the
// result register is free or draining, and registers the result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aled_back
  import aled_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire aled_cfg_t  cfg,
  input  wire logic       q_not_empty,
  input  wire aled_item_t q_head,
  output      logic       q_pop,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_line_level,
  output      logic       out_busy_res,
  output      logic       out_rejected
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  logic [1:0]          phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;
  logic [PIXEL_W-1:0]  color_shift_r, color_shift_nxt;
  logic [BITCNT_W-1:0] bits_left_r, bits_left_nxt;
  logic [TICK_W-1:0]   tick_dec;
  logic                rej;

  logic out_valid_r, out_valid_nxt;
  logic line_r, busy_r, rej_r;

  // Advance when the output register is free or being drained
  assign q_pop    = q_not_empty && (!out_valid_r || !out_stall);
  assign tick_dec = tick_count_r - TICK_W'(1);

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    color_shift_nxt = color_shift_r;
    bits_left_nxt   = bits_left_r;
    rej             = 1'b0;
    unique case (q_head.op)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_count_nxt = tick_dec;
          if (tick_dec == '0) begin
            unique case (phase_r)
              PH_HIGH: begin
                phase_nxt      = PH_LOW;
                tick_count_nxt = low_time(color_shift_r[PIXEL_W-1], cfg);
              end
              PH_LOW: begin
                color_shift_nxt = {color_shift_r[PIXEL_W-2:0], 1'b0};
                bits_left_nxt   = bits_left_r - BITCNT_W'(1);
                if (bits_left_r == BITCNT_W'(1)) begin
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt      = PH_HIGH;
                  tick_count_nxt = high_time(color_shift_r[PIXEL_W-2], cfg);
                end
              end
              PH_LATCH: phase_nxt = PH_IDLE;
              PH_IDLE:  phase_nxt = PH_IDLE;
              default:  phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      OP_PIXEL: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          color_shift_nxt = q_head.color;
          bits_left_nxt   = BITCNT_W'(PIXEL_W);
          phase_nxt       = PH_HIGH;
          tick_count_nxt  = high_time(q_head.color[PIXEL_W-1], cfg);
        end
      end
      OP_LATCH: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          phase_nxt      = PH_LATCH;
          tick_count_nxt = at_least_one(cfg.latch);
        end
      end
      OP_NONE: begin
        phase_nxt = phase_r;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      color_shift_r <= '0;
      bits_left_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r       <= phase_nxt;
        tick_count_r  <= tick_count_nxt;
        color_shift_r <= color_shift_nxt;
        bits_left_r   <= bits_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_r <= (phase_nxt == PH_HIGH);
      busy_r <= (phase_nxt != PH_IDLE);
      rej_r  <= rej;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = line_r;
  assign out_busy_res   = busy_r;
  assign out_rejected   = rej_r;

endmodule

`default_nettype wire

// ===== src/addressable_led_pulse_encoder_core.sv =====
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder_core
// Single-wire addressable LED serializer: request decoder, two-entry queue,
// pulse engine and APB tick-count registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   req_type, red, green, blue
//  out_     output     out_valid / out_stall line_level, busy_res, rejected
//  cfg_     APB slave  psel, penable, pready one_high .. latch tick counts
//
//  One request per clock sustained while out_stall is low; the pulse engine
//  computes its next state combinationally, so the queue-to-output step
//  sets the rate. A result is valid in the cycle after its request is
//  popped; accepted requests pass a queue entry, then the result register.
//  Reset: synchronous, active low; registers return to their default counts.
//  Stalls: in_stall rises only when the two-entry queue is full; out_stall
//  holds the result register and backs up the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module addressable_led_pulse_encoder_core
  import aled_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [COLOR_W-1:0]    in_red,
  input  wire logic [COLOR_W-1:0]    in_green,
  input  wire logic [COLOR_W-1:0]    in_blue,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  out_line_level,
  output      logic                  out_busy_res,
  output      logic                  out_rejected,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output      logic [APB_DATA_W-1:0] cfg_prdata,
  output      logic                  cfg_pready
);

  aled_item_t push_item;
  aled_item_t head;
  aled_cfg_t  cfg;
  logic       push, full, pop, not_empty;

  aled_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .q_full      (full),
    .q_push      (push),
    .q_item      (push_item)
  );

  aled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  aled_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  aled_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_not_empty    (not_empty),
    .q_head         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

endmodule

`default_nettype wire

// ===== src/aled_checker.sv =====
// ----------------------------------------------------------------------------
// aled_checker
// Port-level checks for the LED pulse encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "addressable_led_pulse_encoder_core_macros.svh"

module aled_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_line_level,
  input wire logic out_busy_res,
  input wire logic out_rejected
);

  logic       out_held;
  logic [2:0] out_pl;

  assign out_held = out_valid && out_stall;
  assign out_pl   = {out_line_level, out_busy_res, out_rejected};

  // A held result transfer keeps its payload
  `ALED_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_pl), "held result changed")

  // The line is only driven high during a pixel bit
  `ALED_ASSERT_ALWAYS(a_high_busy, !out_valid || !out_line_level || out_busy_res, "line high while idle")

  // A refused request leaves the engine busy
  `ALED_ASSERT_ALWAYS(a_rej_busy, !out_valid || !out_rejected || out_busy_res, "rejected while idle")

endmodule

bind addressable_led_pulse_encoder_core aled_checker u_aled_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_line_level (out_line_level),
  .out_busy_res   (out_busy_res),
  .out_rejected   (out_rejected)
);

`default_nettype wire
